/* design/ssnpp_pkg.sv */
// shared constants, types and register codes for the screen-space nearest point pick block
// no dependencies
package ssnpp_pkg;

	localparam int CRD_W = 32;
	localparam int ENT_W = 16;
	localparam int PRD_W = ENT_W + CRD_W;
	localparam int ACC_W = 51;
	localparam int QTN_W = 31;
	localparam int NDC_W = 32;
	localparam int PIX_W = 50;
	localparam int SCR_W = 16;
	localparam int PCK_W = 32;
	localparam int DST_W = 64;
	localparam int CNT_W = 16;
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 64;
	localparam int ROW_W = 64;
	localparam int FRAC_W = 16;

	typedef enum logic [CFG_IW-1:0] {
		CFG_ROW0   = 3'd0,
		CFG_ROW1   = 3'd1,
		CFG_ROW2   = 3'd2,
		CFG_ROW3   = 3'd3,
		CFG_WIDTH  = 3'd4,
		CFG_HEIGHT = 3'd5,
		CFG_PICK_X = 3'd6,
		CFG_PICK_Y = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] px;
		logic signed [ACC_W-1:0] py;
		logic signed [ACC_W-1:0] pw;
		logic                    vis;
		logic                    last;
	} proj_t;

endpackage

/* design/ssnpp_if.sv */
// point input and pick result channel interfaces
// depends on ssnpp_pkg
interface ssnpp_point_if import ssnpp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [CRD_W-1:0] point_x;
	logic signed [CRD_W-1:0] point_y;
	logic signed [CRD_W-1:0] point_z;
	logic                    last_point;

	modport source (output valid, point_x, point_y, point_z, last_point, input ready);
	modport sink (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface ssnpp_pick_if import ssnpp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [CNT_W-1:0] closest_index;
	logic [DST_W-1:0] min_sqr_distance;

	modport source (output valid, found, closest_index, min_sqr_distance, input ready);
	modport sink (input valid, found, closest_index, min_sqr_distance, output ready);
endinterface

/* design/screen_space_nearest_point_pick.sv */
// screen-space nearest point pick: configuration registers, front end, queue, back end
// depends on ssnpp_pkg, ssnpp_if, ssnpp_front, ssnpp_fifo, ssnpp_back
//
// points arrive on in_ch (valid/ready, one transfer per point, last_point closes a pass)
// and one result per pass leaves on out_ch when the last point has been processed.
// the front end handles one point at a time: twelve matrix products through one
// shared 16x32 multiplier, each multiplied and then accumulated.
// for a visible point the back end runs the two bit-serial dividers (31 quotient bits,
// x and y in parallel), then mapping, squaring and update; a skipped point goes straight
// to the update. a two-entry queue lets front and back run apart; each end takes a new
// point only when it is through with the last one.
// a result appears the cycle after the back end's update of the last point.
// the result sits in an output register; while out_ch stalls, points keep flowing
// until the next last point, which then waits for the register to empty.
// configuration is written through cfg_we/cfg_index/cfg_data while the block is idle.
// reset clears the pass state and loads register defaults (1920x1080 screen).
module screen_space_nearest_point_pick import ssnpp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	ssnpp_point_if.sink       in_ch,
	ssnpp_pick_if.source      out_ch,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	logic [3:0][ROW_W-1:0] matrix_q;
	logic [SCR_W-1:0]      width_q, height_q;
	logic [PCK_W-1:0]      pick_x_q, pick_y_q;
	proj_t                 f_item, b_item;
	logic                  f_valid, f_ready, b_valid, b_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_q <= '0;
			width_q  <= 16'd1920;
			height_q <= 16'd1080;
			pick_x_q <= '0;
			pick_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ROW0:   matrix_q[0] <= cfg_data;
				CFG_ROW1:   matrix_q[1] <= cfg_data;
				CFG_ROW2:   matrix_q[2] <= cfg_data;
				CFG_ROW3:   matrix_q[3] <= cfg_data;
				CFG_WIDTH:  width_q     <= cfg_data[SCR_W-1:0];
				CFG_HEIGHT: height_q    <= cfg_data[SCR_W-1:0];
				CFG_PICK_X: pick_x_q    <= cfg_data[PCK_W-1:0];
				CFG_PICK_Y: pick_y_q    <= cfg_data[PCK_W-1:0];
				default: ;
			endcase
		end
	end

	ssnpp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.matrix     (matrix_q),
		.item       (f_item),
		.item_valid (f_valid),
		.item_ready (f_ready)
	);

	ssnpp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_data  (f_item),
		.push_ready (f_ready),
		.pop_valid  (b_valid),
		.pop_data   (b_item),
		.pop_ready  (b_ready)
	);

	ssnpp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (b_valid),
		.q_item        (b_item),
		.q_ready       (b_ready),
		.screen_width  (width_q),
		.screen_height (height_q),
		.pick_x        (pick_x_q),
		.pick_y        (pick_y_q),
		.out_ch        (out_ch)
	);

endmodule

/* design/ssnpp_front.sv */
// front end: accepts a point and projects it through the matrix with one shared multiplier
// depends on ssnpp_pkg and ssnpp_if
module ssnpp_front import ssnpp_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	ssnpp_point_if.sink                 in_ch,
	input  logic [3:0][ROW_W-1:0]       matrix,
	output proj_t                       item,
	output logic                        item_valid,
	input  logic                        item_ready
);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_MUL  = 4'b0010,
		F_ACC  = 4'b0100,
		F_PUSH = 4'b1000
	} f_state_t;

	f_state_t                state_q;
	logic [1:0]              row_q;
	logic [1:0]              col_q;
	logic signed [CRD_W-1:0] x_q, y_q, z_q;
	logic                    last_q;
	logic signed [ACC_W-1:0] acc_q [4];
	logic signed [PRD_W-1:0] prod_s1;
	logic signed [ENT_W-1:0] ent;
	logic signed [CRD_W-1:0] crd;

	assign ent = $signed(matrix[row_q][{col_q, 4'b0000} +: ENT_W]);

	always_comb begin
		case (col_q)
			2'd0:    crd = x_q;
			2'd1:    crd = y_q;
			default: crd = z_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_ch.valid) begin
						row_q   <= '0;
						col_q   <= '0;
						state_q <= F_MUL;
					end
				end
				F_MUL: state_q <= F_ACC;
				F_ACC: begin
					if (col_q == 2'd2) begin
						col_q <= '0;
						if (row_q == 2'd3) begin
							state_q <= F_PUSH;
						end else begin
							row_q   <= row_q + 2'd1;
							state_q <= F_MUL;
						end
					end else begin
						col_q   <= col_q + 2'd1;
						state_q <= F_MUL;
					end
				end
				F_PUSH: begin
					if (item_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_ch.valid) begin
			x_q    <= in_ch.point_x;
			y_q    <= in_ch.point_y;
			z_q    <= in_ch.point_z;
			last_q <= in_ch.last_point;
			for (int r = 0; r < 4; r++) begin
				acc_q[r] <= {{(ACC_W-ENT_W-FRAC_W){matrix[r][ROW_W-1]}},
					matrix[r][ROW_W-1 -: ENT_W], {FRAC_W{1'b0}}};
			end
		end
		if (state_q == F_MUL) begin
			prod_s1 <= ent * crd;
		end
		if (state_q == F_ACC) begin
			acc_q[row_q] <= acc_q[row_q] + ACC_W'(prod_s1);
		end
	end

	assign in_ch.ready = (state_q == F_IDLE);
	assign item_valid  = (state_q == F_PUSH);
	assign item.px     = acc_q[0];
	assign item.py     = acc_q[1];
	assign item.pw     = acc_q[3];
	assign item.vis    = (acc_q[2] > 0) && (acc_q[3] != 0);
	assign item.last   = last_q;

endmodule

/* design/ssnpp_fifo.sv */
// two-entry queue of projected points between front and back
// depends on ssnpp_pkg
module ssnpp_fifo import ssnpp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	input  proj_t push_data,
	output logic  push_ready,
	output logic  pop_valid,
	output proj_t pop_data,
	input  logic  pop_ready
);

	proj_t      mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (!do_push && do_pop) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

endmodule

/* design/ssnpp_div.sv */
// bit-serial divider giving num / den as saturated signed q16.16
// depends on ssnpp_pkg
module ssnpp_div import ssnpp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] num,
	input  logic signed [ACC_W-1:0] den,
	output logic                    busy,
	output logic signed [NDC_W-1:0] quot
);

	logic             busy_q;
	logic [4:0]       cnt_q;
	logic [ACC_W-1:0] rem_q, dvs_q;
	logic [QTN_W-1:0] nb_q, q_q;
	logic             neg_q;
	logic [ACC_W-1:0] un, ud;
	logic             sat;
	logic [ACC_W:0]   r2;
	logic             ge;

	assign un  = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
	assign ud  = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
	assign sat = {15'b0, un} >= {ud, 15'b0};
	assign r2  = {rem_q, nb_q[QTN_W-1]};
	assign ge  = r2 >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !sat;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'(QTN_W - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[ACC_W-1] ^ den[ACC_W-1];
			dvs_q <= ud;
			rem_q <= un >> (QTN_W - FRAC_W);
			nb_q  <= {un[QTN_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
			q_q   <= sat ? '1 : '0;
		end else if (busy_q) begin
			rem_q <= ge ? ACC_W'(r2 - {1'b0, dvs_q}) : r2[ACC_W-1:0];
			nb_q  <= nb_q << 1;
			q_q   <= {q_q[QTN_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

endmodule

/* design/ssnpp_back.sv */
// back end: divide, viewport mapping, squared distance, nearest tracking and result register
// depends on ssnpp_pkg, ssnpp_if and ssnpp_div
module ssnpp_back import ssnpp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  proj_t            q_item,
	output logic             q_ready,
	input  logic [SCR_W-1:0] screen_width,
	input  logic [SCR_W-1:0] screen_height,
	input  logic [PCK_W-1:0] pick_x,
	input  logic [PCK_W-1:0] pick_y,
	ssnpp_pick_if.source     out_ch
);

	typedef enum logic [5:0] {
		B_IDLE = 6'b000001,
		B_DIV  = 6'b000010,
		B_PIX  = 6'b000100,
		B_DLT  = 6'b001000,
		B_SQR  = 6'b010000,
		B_UPD  = 6'b100000
	} b_state_t;

	b_state_t                state_q;
	logic                    vis_q, last_q;
	logic                    busy_x, busy_y;
	logic signed [NDC_W-1:0] quot_x, quot_y;
	logic signed [PIX_W-1:0] tx_s1, ty_s1;
	logic [PCK_W:0]          magx_s2, magy_s2;
	logic [DST_W-1:0]        sqx_s3, sqy_s3;
	logic [DST_W-1:0]        best_q;
	logic [CNT_W-1:0]        idx_q, cnt_q;
	logic                    any_q;
	logic                    ov_q, found_q;
	logic [CNT_W-1:0]        oidx_q;
	logic [DST_W-1:0]        odist_q;
	logic                    div_start;
	logic [DST_W:0]          sum;
	logic [DST_W-1:0]        cand_dist, nbest;
	logic [CNT_W-1:0]        nidx;
	logic                    take, nany, out_free, upd_go;

	function automatic logic [PCK_W:0] pix_mag(logic signed [PIX_W-1:0] t,
		logic [PCK_W-1:0] pick);
		logic signed [PIX_W-1:0] h, d;
		logic [PIX_W-1:0]        m;
		h = (t + $signed({{(PIX_W-1){1'b0}}, t[PIX_W-1]})) >>> 1;
		d = $signed({{(PIX_W-PCK_W){1'b0}}, pick}) - h;
		m = d[PIX_W-1] ? PIX_W'(-d) : PIX_W'(d);
		return {|m[PIX_W-1:PCK_W], m[PCK_W-1:0]};
	endfunction

	function automatic logic signed [PIX_W-1:0] pix_scale(logic signed [NDC_W-1:0] ndc,
		logic [SCR_W-1:0] size);
		logic signed [NDC_W:0] n;
		n = (NDC_W+1)'(ndc) + $signed({1'b0, 16'd0, 16'h0}) + (NDC_W+1)'(33'sd65536);
		return n * $signed({1'b0, size});
	endfunction

	assign div_start = (state_q == B_IDLE) && q_valid && q_item.vis;
	assign q_ready   = (state_q == B_IDLE);

	ssnpp_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (q_item.px),
		.den    (q_item.pw),
		.busy   (busy_x),
		.quot   (quot_x)
	);

	ssnpp_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (q_item.py),
		.den    (q_item.pw),
		.busy   (busy_y),
		.quot   (quot_y)
	);

	assign sum       = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	assign cand_dist = sum[DST_W] ? '1 : sum[DST_W-1:0];
	assign take      = vis_q && (!any_q || cand_dist < best_q);
	assign nany      = any_q || take;
	assign nbest     = take ? cand_dist : best_q;
	assign nidx      = take ? cnt_q : idx_q;
	assign out_free  = !ov_q || out_ch.ready;
	assign upd_go    = (state_q == B_UPD) && (!last_q || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			best_q  <= '1;
			idx_q   <= '0;
			any_q   <= 1'b0;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (ov_q && out_ch.ready) ov_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (q_valid) state_q <= q_item.vis ? B_DIV : B_UPD;
				end
				B_DIV: begin
					if (!busy_x && !busy_y) state_q <= B_PIX;
				end
				B_PIX: state_q <= B_DLT;
				B_DLT: state_q <= B_SQR;
				B_SQR: state_q <= B_UPD;
				B_UPD: begin
					if (upd_go) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= B_IDLE;
						if (last_q) begin
							ov_q   <= 1'b1;
							best_q <= '1;
							idx_q  <= '0;
							any_q  <= 1'b0;
							cnt_q  <= '0;
						end else begin
							best_q <= nbest;
							idx_q  <= nidx;
							any_q  <= nany;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && q_valid) begin
			vis_q  <= q_item.vis;
			last_q <= q_item.last;
		end
		if (state_q == B_PIX) begin
			tx_s1 <= pix_scale(quot_x, screen_width);
			ty_s1 <= pix_scale(quot_y, screen_height);
		end
		if (state_q == B_DLT) begin
			magx_s2 <= pix_mag(tx_s1, pick_x);
			magy_s2 <= pix_mag(ty_s1, pick_y);
		end
		if (state_q == B_SQR) begin
			sqx_s3 <= magx_s2[PCK_W] ? '1 :
				DST_W'(magx_s2[PCK_W-1:0]) * DST_W'(magx_s2[PCK_W-1:0]);
			sqy_s3 <= magy_s2[PCK_W] ? '1 :
				DST_W'(magy_s2[PCK_W-1:0]) * DST_W'(magy_s2[PCK_W-1:0]);
		end
		if (upd_go && last_q) begin
			found_q <= nany;
			oidx_q  <= nany ? nidx : '0;
			odist_q <= nany ? nbest : '0;
		end
	end

	assign out_ch.valid            = ov_q;
	assign out_ch.found            = found_q;
	assign out_ch.closest_index    = oidx_q;
	assign out_ch.min_sqr_distance = odist_q;

	a_empty_pass_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !found_q) |-> (oidx_q == '0 && odist_q == '0))
		else $error("empty pass result carries nonzero fields");

	a_best_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!any_q |-> (best_q == '1 && idx_q == '0))
		else $error("best distance moved without a visible point");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && last_q) |=> (ov_q && cnt_q == '0 && !any_q))
		else $error("last point did not produce a result and clear the pass");

	a_div_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV) |-> vis_q)
		else $error("division running for a skipped point");

endmodule
